[hdl/frc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

  // Fixed field widths of the stream items and the batch register.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LEN_W = 13;
  localparam int unsigned TOTAL_W = 29;
  localparam int unsigned RUNS_W = 16;

  // Packed widths of the stream payloads, padded to whole bytes.
  localparam int unsigned IN_TDATA_W = 16;
  localparam int unsigned OUT_TDATA_W = 48;

  // Saturation limits of the counters.
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [RUNS_W-1:0] RUNS_MAX = {RUNS_W{1'b1}};
  localparam logic [RUNS_W-1:0] RUNS_PER_BATCH_RST = RUNS_W'(1);

  // Default size of the sampled index space.
  localparam int unsigned INDEX_SPACE_DEF = 4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;        // clear one bitmap entry of the power-up sweep
    logic capture;        // register the accepted sample
    logic lookup;         // read the bitmap at the sample's index
    logic commit_fresh;   // mark and list a new index
    logic commit_repeat;  // close the run and load the result
    logic clr_step;       // advance the walk that clears the listed marks
    logic clr_finish;     // end of the walk, restart the list
  } frc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // looked-up index was already marked
    logic out_free;   // result register can take a new item
    logic init_last;  // power-up sweep is at its last entry
    logic clr_done;   // every listed mark has been cleared
  } frc_stat_t;

endpackage

`default_nettype wire

[hdl/frc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module frc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/frc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module frc_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                s_tvalid_i,
  output logic               s_tready_o,
  input  frc_pkg::frc_stat_t st_i,
  output frc_pkg::frc_cmd_t  cmd_o
);

  import frc_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_WAIT,
    ST_RD,
    ST_DEC,
    ST_CLR
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  // The input side opens when idle, and in the cycle that marks a fresh index.
  assign s_tready_o = (state_q == ST_WAIT) || (state_q == ST_DEC && !st_i.hit);
  assign accept = s_tvalid_i && s_tready_o;

  // Command decode and next state.
  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    cmd_o.capture = accept;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (st_i.init_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (accept) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.lookup = 1'b1;
        state_d = ST_DEC;
      end
      ST_DEC: begin
        if (!st_i.hit) begin
          cmd_o.commit_fresh = 1'b1;
          state_d = accept ? ST_RD : ST_WAIT;
        end else if (st_i.out_free) begin
          cmd_o.commit_repeat = 1'b1;
          state_d = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_done) begin
          cmd_o.clr_finish = 1'b1;
          state_d = ST_WAIT;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // No item enters during the power-up sweep, the lookup or the clearing walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT || state_q == ST_RD || state_q == ST_CLR) |-> !s_tready_o)
    else $error("input accepted while the bitmap is busy");

  // A run is closed only when the result register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit_repeat |-> st_i.out_free)
    else $error("result loaded over a pending item");

  // A repeat with a blocked output waits in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC && st_i.hit && !st_i.out_free) |=> state_q == ST_DEC)
    else $error("repeat left the decide state without a free output");

endmodule

`default_nettype wire

[hdl/frc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module frc_dp #(
  parameter int unsigned INDEX_SPACE = frc_pkg::INDEX_SPACE_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  frc_pkg::frc_cmd_t                cmd_i,
  output frc_pkg::frc_stat_t               st_o,
  input  wire  [frc_pkg::SAMPLE_W-1:0]     sample_i,
  input  wire                              cfg_we_i,
  input  wire  [frc_pkg::RUNS_W-1:0]       cfg_wdata_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [frc_pkg::LEN_W-1:0]        run_length_o,
  output logic [frc_pkg::TOTAL_W-1:0]      batch_total_o,
  output logic                             batch_done_o
);

  import frc_pkg::*;

  localparam int unsigned IDX_W = $clog2(INDEX_SPACE);
  localparam int unsigned CNT_W = $clog2(INDEX_SPACE + 1);
  localparam bit POW2 = (INDEX_SPACE & (INDEX_SPACE - 1)) == 0;
  localparam bit WRAP_MOD = (INDEX_SPACE < (1 << SAMPLE_W)) && !POW2;

  logic [SAMPLE_W-1:0] sample_q;
  logic [IDX_W-1:0]    idx;

  logic [CNT_W-1:0]    ptr_q;
  logic [CNT_W-1:0]    seen_count_q;
  logic                pend_q;
  logic [LEN_W-1:0]    draw_q;
  logic [RUNS_W-1:0]   runs_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [RUNS_W-1:0]   rpb_q;

  logic                visited_we;
  logic [IDX_W-1:0]    visited_waddr;
  logic                visited_rdata;
  logic [IDX_W-1:0]    seen_rdata;
  logic                clr_issue;
  logic                clr_wr;

  logic [LEN_W-1:0]    len;
  logic [TOTAL_W:0]    total_sum;
  logic [TOTAL_W-1:0]  total_new;
  logic [RUNS_W-1:0]   runs_new;
  logic [RUNS_W-1:0]   limit;
  logic                done;
  logic                out_load;

  // Sample capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
  end

  // Reduction of the sample into the index space.
  generate
    if (WRAP_MOD) begin : g_mod
      // Quotient by reciprocal, exact for every 12-bit sample.
      localparam int unsigned RECIP = ((1 << 24) + INDEX_SPACE - 1) / INDEX_SPACE;
      logic [SAMPLE_W+23:0] qprod;
      logic [SAMPLE_W-1:0]  q_q;
      logic [2*SAMPLE_W-1:0] back;
      logic [SAMPLE_W-1:0]  rem;

      assign qprod = {24'b0, sample_i} * (SAMPLE_W + 24)'(RECIP);
      always_ff @(posedge clk_i) begin
        if (cmd_i.capture) begin
          q_q <= qprod[SAMPLE_W+23:24];
        end
      end
      assign back = q_q * SAMPLE_W'(INDEX_SPACE);
      assign rem = sample_q - back[SAMPLE_W-1:0];
      assign idx = rem[IDX_W-1:0];
    end else if (IDX_W < SAMPLE_W) begin : g_mask
      assign idx = sample_q[IDX_W-1:0];
    end else begin : g_wide
      assign idx = IDX_W'(sample_q);
    end
  endgenerate

  // Clearing walk: read one listed index a cycle, clear its mark in the next cycle.
  assign clr_issue = cmd_i.clr_step && (ptr_q < seen_count_q);
  assign clr_wr = cmd_i.clr_step && pend_q;

  // Bitmap write port: power-up sweep, new mark, or cleared mark.
  assign visited_we = cmd_i.init_wr || cmd_i.commit_fresh || clr_wr;
  always_comb begin
    if (cmd_i.init_wr) begin
      visited_waddr = ptr_q[IDX_W-1:0];
    end else if (clr_wr) begin
      visited_waddr = seen_rdata;
    end else begin
      visited_waddr = idx;
    end
  end

  frc_ram #(
    .WIDTH(1),
    .DEPTH(INDEX_SPACE)
  ) u_visited (
    .clk_i  (clk_i),
    .we_i   (visited_we),
    .waddr_i(visited_waddr),
    .wdata_i(cmd_i.commit_fresh),
    .re_i   (cmd_i.lookup),
    .raddr_i(idx),
    .rdata_o(visited_rdata)
  );

  frc_ram #(
    .WIDTH(IDX_W),
    .DEPTH(INDEX_SPACE)
  ) u_seen (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit_fresh),
    .waddr_i(seen_count_q[IDX_W-1:0]),
    .wdata_i(idx),
    .re_i   (clr_issue),
    .raddr_i(ptr_q[IDX_W-1:0]),
    .rdata_o(seen_rdata)
  );

  // Run closing arithmetic, all saturating.
  assign len = (draw_q == LEN_MAX) ? LEN_MAX : draw_q + LEN_W'(1);
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(len);
  assign total_new = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
  assign runs_new = (runs_q == RUNS_MAX) ? RUNS_MAX : runs_q + RUNS_W'(1);
  assign limit = (rpb_q == '0) ? RUNS_W'(1) : rpb_q;
  assign done = runs_new >= limit;
  assign out_load = cmd_i.commit_repeat;

  // Counters, batch register and walk pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      seen_count_q <= '0;
      pend_q <= 1'b0;
      draw_q <= '0;
      runs_q <= '0;
      total_q <= '0;
      rpb_q <= RUNS_PER_BATCH_RST;
    end else begin
      if (cfg_we_i) begin
        rpb_q <= cfg_wdata_i;
      end
      if (cmd_i.init_wr) begin
        ptr_q <= st_o.init_last ? '0 : ptr_q + CNT_W'(1);
      end else if (cmd_i.clr_finish) begin
        ptr_q <= '0;
      end else if (clr_issue) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
      if (cmd_i.clr_step) begin
        pend_q <= clr_issue;
      end
      if (cmd_i.commit_fresh) begin
        seen_count_q <= seen_count_q + CNT_W'(1);
        draw_q <= len;
      end else if (cmd_i.clr_finish) begin
        seen_count_q <= '0;
      end
      if (cmd_i.commit_repeat) begin
        draw_q <= '0;
        runs_q <= done ? '0 : runs_new;
        total_q <= done ? '0 : total_new;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      run_length_o <= len;
      batch_total_o <= done ? total_new : '0;
      batch_done_o <= done;
    end
  end

  // Status back to the controller.
  assign st_o.hit = visited_rdata;
  assign st_o.out_free = !out_valid_o || out_ready_i;
  assign st_o.init_last = ptr_q == CNT_W'(INDEX_SPACE - 1);
  assign st_o.clr_done = !(ptr_q < seen_count_q) && !pend_q;

  // The list never holds more entries than the index space.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_count_q <= CNT_W'(INDEX_SPACE))
    else $error("seen list overflow");

  // A pending clear always comes from a read issued by the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(cmd_i.clr_step))
    else $error("pending clear without a walk step");

  // Every closed run was preceded by a marked index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_repeat |-> (seen_count_q != '0))
    else $error("repeat with an empty seen list");

endmodule

`default_nettype wire

[hdl/first_repeat_run_counter.sv]
// A repeating sample is captured, read from the bitmap and decided on, and its result item is
// then registered and offered. A fresh sample passes a bitmap read, then a mark; the next one
// can be accepted while it is marked. A repeating sample passes read, decide, a clearing walk
// over the listed marks and the idle state up to the next accepted item; a blocked result
// adds its stall. Reset: the visited bitmap is swept to zero entry by entry, input held off.
// Configuration writes are taken in any cycle, also during that sweep.
`timescale 1ns / 1ps
`default_nettype none

module first_repeat_run_counter #(
  parameter int unsigned INDEX_SPACE = frc_pkg::INDEX_SPACE_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Input item.
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [frc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [11:0] sample_index
  // Result item.
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [frc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [12:0] run_length,
                                                            // [41:13] batch_total
  output logic                               m_axis_tuser,  // [0] batch_done
  // Batch size register.
  input  wire                                cfg_we_i,
  input  wire  [frc_pkg::RUNS_W-1:0]         cfg_wdata_i
);

  import frc_pkg::*;

  frc_cmd_t            cmd;
  frc_stat_t           st;
  logic [LEN_W-1:0]    run_length;
  logic [TOTAL_W-1:0]  batch_total;

  frc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  frc_dp #(
    .INDEX_SPACE(INDEX_SPACE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .sample_i     (s_axis_tdata[SAMPLE_W-1:0]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .run_length_o (run_length),
    .batch_total_o(batch_total),
    .batch_done_o (m_axis_tuser)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {(OUT_TDATA_W - LEN_W - TOTAL_W)'(0), batch_total, run_length};

endmodule

`default_nettype wire
